[design/ltc_pkg.sv]
`timescale 1ns / 1ps

package ltc_pkg;

  // Default saturation point of the digit counter
  localparam int DIGIT_SAT_DEFAULT = 63;

  // Depth of the token queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration register
  localparam int          THRESH_W     = 6;
  localparam logic [5:0]  THRESH_RESET = 6'd7;

  // Digit-count limits of the integer checks
  localparam int LONG_DIGITS     = 10;
  localparam int UNSIGNED_DIGITS = 6;

  // Token bytes of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_LX     = 8'h78;

  // Boolean words, one candidate bit each
  localparam logic [1:0] W_FALSE_LC = 2'd0;
  localparam logic [1:0] W_TRUE_LC  = 2'd1;
  localparam logic [1:0] W_TRUE_UC  = 2'd2;
  localparam logic [1:0] W_FALSE_UC = 2'd3;

  localparam logic [39:0] TXT_FALSE_LC = "false";
  localparam logic [39:0] TXT_TRUE_LC  = {"true", 8'h00};
  localparam logic [39:0] TXT_TRUE_UC  = {"TRUE", 8'h00};
  localparam logic [39:0] TXT_FALSE_UC = "FALSE";

  typedef enum logic [3:0] {
    TC_NULL     = 4'd0,
    TC_STRING   = 4'd1,
    TC_CHAR     = 4'd2,
    TC_DOUBLE   = 4'd3,
    TC_FLOAT    = 4'd4,
    TC_LONG     = 4'd5,
    TC_INT      = 4'd6,
    TC_UNSIGNED = 4'd7,
    TC_HEX      = 4'd8,
    TC_BOOL     = 4'd9,
    TC_UNKNOWN  = 4'd10
  } type_code_t;

  // Per-token summary handed from front to back
  typedef struct packed {
    logic [2:0] length_sat;
    logic [1:0] decimal_count;
    logic       minus_seen;
    logic       upper_hex_seen;
    logic       x_seen;
    logic       non_numeric_seen;
    logic [1:0] non_hexdigit_count;
    logic [7:0] first_byte;
    logic [7:0] third_byte;
    logic [7:0] last_byte;
    logic [3:0] bool_match;
  } token_sum_t;

  // Summary of an empty token: everything clear, all boolean words alive
  localparam token_sum_t SUM_CLEAR = '{
    length_sat:         3'd0,
    decimal_count:      2'd0,
    minus_seen:         1'b0,
    upper_hex_seen:     1'b0,
    x_seen:             1'b0,
    non_numeric_seen:   1'b0,
    non_hexdigit_count: 2'd0,
    first_byte:         8'h00,
    third_byte:         8'h00,
    last_byte:          8'h00,
    bool_match:         4'hF
  };

  // Length of a boolean word
  function automatic logic [2:0] word_len(input logic [1:0] k);
    logic [2:0] len;
    case (k)
      W_FALSE_LC: len = 3'd5;
      W_TRUE_LC:  len = 3'd4;
      W_TRUE_UC:  len = 3'd4;
      W_FALSE_UC: len = 3'd5;
      default:    len = 3'd0;
    endcase
    return len;
  endfunction

  // Byte of a boolean word at a position
  function automatic logic [7:0] word_byte(input logic [1:0] k, input logic [2:0] pos);
    logic [39:0] w;
    logic [7:0]  b;
    case (k)
      W_FALSE_LC: w = TXT_FALSE_LC;
      W_TRUE_LC:  w = TXT_TRUE_LC;
      W_TRUE_UC:  w = TXT_TRUE_UC;
      W_FALSE_UC: w = TXT_FALSE_UC;
      default:    w = '0;
    endcase
    case (pos)
      3'd0:    b = w[39:32];
      3'd1:    b = w[31:24];
      3'd2:    b = w[23:16];
      3'd3:    b = w[15:8];
      3'd4:    b = w[7:0];
      default: b = CH_NUL;
    endcase
    return b;
  endfunction

endpackage

[design/ltc_front.sv]
`timescale 1ns / 1ps

module ltc_front #(
  parameter int DIGIT_SAT = ltc_pkg::DIGIT_SAT_DEFAULT,
  parameter int DW        = $clog2(DIGIT_SAT + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  logic [7:0]          ch,
  output logic                q_push,
  output ltc_pkg::token_sum_t q_sum,
  output logic [DW-1:0]       q_digits
);

  ltc_pkg::token_sum_t st, st_next;
  logic [DW-1:0]       digits, digits_next;
  logic                take;
  logic                is_digit;
  logic                is_uhex;

  assign take = push && !full;

  // Hand the finished token to the queue on the terminating zero beat
  assign q_push   = take && (ch == ltc_pkg::CH_NUL);
  assign q_sum    = st;
  assign q_digits = digits;

  // Update token flags and counters
  always_comb begin
    is_digit    = (ch >= ltc_pkg::CH_ZERO) && (ch <= ltc_pkg::CH_NINE);
    is_uhex     = (ch >= ltc_pkg::CH_UA) && (ch <= ltc_pkg::CH_UF);
    st_next     = st;
    digits_next = digits;
    if (take && (ch != ltc_pkg::CH_NUL)) begin
      for (int k = 0; k < 4; k++) begin
        if (!((st.length_sat < ltc_pkg::word_len(2'(k))) &&
              (ltc_pkg::word_byte(2'(k), st.length_sat) == ch))) begin
          st_next.bool_match[k] = 1'b0;
        end
      end
      if (st.length_sat == 3'd0) begin
        st_next.first_byte = ch;
      end
      if (st.length_sat == 3'd2) begin
        st_next.third_byte = ch;
      end
      st_next.last_byte = ch;
      if (ch == ltc_pkg::CH_DOT) begin
        if (st.decimal_count != 2'd3) begin
          st_next.decimal_count = st.decimal_count + 2'd1;
        end
      end else if (ch == ltc_pkg::CH_MINUS) begin
        st_next.minus_seen = 1'b1;
      end else if (!is_digit) begin
        st_next.non_numeric_seen = 1'b1;
      end
      if (is_digit && (digits < DW'(DIGIT_SAT))) begin
        digits_next = digits + DW'(1);
      end
      if (is_uhex) begin
        st_next.upper_hex_seen = 1'b1;
      end
      if ((ch == ltc_pkg::CH_LX) || (ch == ltc_pkg::CH_UX)) begin
        st_next.x_seen = 1'b1;
      end
      if (!is_digit && !is_uhex && (st.non_hexdigit_count != 2'd3)) begin
        st_next.non_hexdigit_count = st.non_hexdigit_count + 2'd1;
      end
      if (st.length_sat != 3'd7) begin
        st_next.length_sat = st.length_sat + 3'd1;
      end
    end else if (take) begin
      st_next     = ltc_pkg::SUM_CLEAR;
      digits_next = '0;
    end
  end

  // Hold token state; clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= ltc_pkg::SUM_CLEAR;
      digits <= '0;
    end else begin
      st     <= st_next;
      digits <= digits_next;
    end
  end

endmodule

[design/ltc_fifo.sv]
`timescale 1ns / 1ps

module ltc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ltc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[design/ltc_back.sv]
`timescale 1ns / 1ps

module ltc_back #(
  parameter int DIGIT_SAT = ltc_pkg::DIGIT_SAT_DEFAULT,
  parameter int DW        = $clog2(DIGIT_SAT + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data,
  input  logic                q_empty,
  input  ltc_pkg::token_sum_t q_sum,
  input  logic [DW-1:0]       q_digits,
  output logic                q_pop,
  output logic [3:0]          type_code,
  output logic                empty,
  input  logic                pop
);

  localparam int CW = (DW > ltc_pkg::THRESH_W) ? DW : ltc_pkg::THRESH_W;

  logic [5:0]          thresh;
  logic                out_valid;
  logic                load;
  logic [CW-1:0]       dc;
  logic [CW-1:0]       thr;
  logic                numeric_ok;
  logic                bool_hit;
  ltc_pkg::type_code_t tc;
  ltc_pkg::type_code_t tc_reg;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;
  assign type_code = tc_reg;
  assign load      = !q_empty && (!out_valid || pop);
  assign q_pop     = load;
  assign dc        = CW'(q_digits);
  assign thr       = CW'(thresh);

  // Run the checks in priority order on the queue head
  always_comb begin
    numeric_ok = !q_sum.non_numeric_seen &&
                 (!q_sum.minus_seen || (q_sum.first_byte == ltc_pkg::CH_MINUS));
    bool_hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (q_sum.bool_match[k] && (q_sum.length_sat == ltc_pkg::word_len(2'(k)))) begin
        bool_hit = 1'b1;
      end
    end
    if (q_sum.length_sat == 3'd0) begin
      tc = ltc_pkg::TC_NULL;
    end else if ((q_sum.length_sat >= 3'd2) && (q_sum.first_byte == ltc_pkg::CH_DQUOTE) &&
                 (q_sum.last_byte == ltc_pkg::CH_DQUOTE)) begin
      tc = ltc_pkg::TC_STRING;
    end else if ((q_sum.length_sat == 3'd3) && (q_sum.first_byte == ltc_pkg::CH_SQUOTE) &&
                 (q_sum.third_byte == ltc_pkg::CH_SQUOTE)) begin
      tc = ltc_pkg::TC_CHAR;
    end else if (numeric_ok && (q_sum.decimal_count == 2'd1)) begin
      tc = (dc >= thr) ? ltc_pkg::TC_DOUBLE : ltc_pkg::TC_FLOAT;
    end else if (numeric_ok && (q_sum.decimal_count == 2'd0)) begin
      if (dc >= CW'(ltc_pkg::LONG_DIGITS)) begin
        tc = ltc_pkg::TC_LONG;
      end else if (!q_sum.minus_seen && (dc > CW'(ltc_pkg::UNSIGNED_DIGITS))) begin
        tc = ltc_pkg::TC_UNSIGNED;
      end else begin
        tc = ltc_pkg::TC_INT;
      end
    end else if ((q_sum.upper_hex_seen || q_sum.x_seen) &&
                 (((q_sum.first_byte == ltc_pkg::CH_ZERO) && q_sum.x_seen &&
                   (q_sum.non_hexdigit_count == 2'd1)) ||
                  (q_sum.non_hexdigit_count == 2'd0))) begin
      tc = ltc_pkg::TC_HEX;
    end else if (bool_hit) begin
      tc = ltc_pkg::TC_BOOL;
    end else begin
      tc = ltc_pkg::TC_UNKNOWN;
    end
  end

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= ltc_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thresh <= cfg_data;
    end
  end

  // Result register: load from queue head, drop on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tc_reg <= tc;
    end
  end

endmodule

[design/literal_token_type_classifier.sv]
`timescale 1ns / 1ps
// Result path: an accepted zero byte writes the token summary into the token queue;
//   when the result register is free, it loads the type of the queue head onto type_code.
// Throughput: one byte per cycle while full is low; full rises only when the four-entry token queue is full.
// Reset: synchronous rst clears token state, queue and result register, and sets
//   the double-digit threshold register thresh to 7.
module literal_token_type_classifier #(
  parameter int DIGIT_SAT = ltc_pkg::DIGIT_SAT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] type_code,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  localparam int DW = $clog2(DIGIT_SAT + 1);
  localparam int QW = $bits(ltc_pkg::token_sum_t) + DW;

  logic                q_push;
  logic                q_pop;
  logic                q_empty;
  ltc_pkg::token_sum_t f_sum;
  logic [DW-1:0]       f_digits;
  ltc_pkg::token_sum_t b_sum;
  logic [DW-1:0]       b_digits;
  logic [QW-1:0]       q_rd;

  assign b_sum    = q_rd[QW-1:DW];
  assign b_digits = q_rd[DW-1:0];

  ltc_front #(
    .DIGIT_SAT (DIGIT_SAT),
    .DW        (DW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .ch       (ch),
    .q_push   (q_push),
    .q_sum    (f_sum),
    .q_digits (f_digits)
  );

  ltc_fifo #(
    .WIDTH (QW),
    .DEPTH (ltc_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data ({f_sum, f_digits}),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .full    (full),
    .empty   (q_empty)
  );

  ltc_back #(
    .DIGIT_SAT (DIGIT_SAT),
    .DW        (DW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_sum     (b_sum),
    .q_digits  (b_digits),
    .q_pop     (q_pop),
    .type_code (type_code),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

[design/ltc_checker.sv]
`timescale 1ns / 1ps

module ltc_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic [7:0] ch,
  input logic       empty,
  input logic       pop,
  input logic [3:0] type_code
);

  // Nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result side not empty after reset");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(type_code)))
    else $error("waiting result changed before pop");

  // Only defined type codes leave the block
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (type_code <= 4'(ltc_pkg::TC_UNKNOWN)))
    else $error("type code out of range");

  // A terminating zero beat produces a visible result once it has passed the token queue and the result register
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (push && !full && (ch == ltc_pkg::CH_NUL)) |=> ##1 !empty)
    else $error("no result after token end");

endmodule

bind literal_token_type_classifier ltc_checker u_ltc_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .ch        (ch),
  .empty     (empty),
  .pop       (pop),
  .type_code (type_code)
);
